[sv/ppt_pkg.sv]
package ppt_pkg;

    localparam int ID_W    = 64;
    localparam int TIME_W  = 64;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 1;
    localparam int SLOT_W  = 3;
    localparam int IN_DATA_W  = 2 * ID_W + TIME_W;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [0:0] {
        KIND_REGISTER = 1'b0,
        KIND_QUERY    = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALIVE_TIME  = 1'b0,
        REG_APPEAR_TIME = 1'b1
    } cfg_reg_t;

    // Search token handed from cell to cell
    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   id_high;
        logic [ID_W-1:0]   id_low;
        logic [TIME_W-1:0] now;
        logic              found;
        logic              have_empty;
        logic [TIME_W-1:0] best_age;
        logic [TIME_W-1:0] match_age;
    } token_t;

    // Write-back command broadcast to all cells
    typedef struct packed {
        logic              en;
        logic              set_id;
        logic [ID_W-1:0]   id_high;
        logic [ID_W-1:0]   id_low;
        logic [TIME_W-1:0] now;
    } wb_t;

endpackage

[sv/ppt_cell.sv]
module ppt_cell #(
    parameter int IDX_W    = 3,
    parameter int CELL_IDX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  ppt_pkg::token_t     in_tok,
    input  logic [IDX_W-1:0]    in_match_idx,
    input  logic [IDX_W-1:0]    in_pick_idx,
    output logic                out_valid,
    output ppt_pkg::token_t     out_tok,
    output logic [IDX_W-1:0]    out_match_idx,
    output logic [IDX_W-1:0]    out_pick_idx,
    input  ppt_pkg::wb_t        wb,
    input  logic [IDX_W-1:0]    wb_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [ppt_pkg::ID_W-1:0]   id_high_reg, id_high_next;
    logic [ppt_pkg::ID_W-1:0]   id_low_reg, id_low_next;
    logic [ppt_pkg::TIME_W-1:0] seen_reg, seen_next;

    logic                       valid_reg;
    ppt_pkg::token_t            tok_reg, tok_next;
    logic [IDX_W-1:0]           match_idx_reg, match_idx_next;
    logic [IDX_W-1:0]           pick_idx_reg, pick_idx_next;

    logic                       id_eq;
    logic                       is_empty;
    logic [ppt_pkg::TIME_W-1:0] age;
    logic                       wb_here;

    assign id_eq    = (id_high_reg == in_tok.id_high) && (id_low_reg == in_tok.id_low);
    assign is_empty = (id_high_reg == '0) && (id_low_reg == '0);
    assign age      = in_tok.now - seen_reg;
    assign wb_here  = wb.en && (wb_idx == MY_IDX);

    // Fold this cell into the running search
    always_comb
    begin
        tok_next       = in_tok;
        match_idx_next = in_match_idx;
        pick_idx_next  = in_pick_idx;
        if (!in_tok.found && id_eq)
        begin
            tok_next.found     = 1'b1;
            tok_next.match_age = age;
            match_idx_next     = MY_IDX;
        end
        if (is_empty)
        begin
            tok_next.have_empty = 1'b1;
            pick_idx_next       = MY_IDX;
        end
        else if (!in_tok.have_empty && (age > in_tok.best_age))
        begin
            tok_next.best_age = age;
            pick_idx_next     = MY_IDX;
        end
    end

    always_comb
    begin
        id_high_next = id_high_reg;
        id_low_next  = id_low_reg;
        seen_next    = seen_reg;
        if (wb_here)
        begin
            seen_next = wb.now;
            if (wb.set_id)
            begin
                id_high_next = wb.id_high;
                id_low_next  = wb.id_low;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_high_reg <= '0;
            id_low_reg  <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            id_high_reg <= id_high_next;
            id_low_reg  <= id_low_next;
            valid_reg   <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        seen_reg      <= seen_next;
        tok_reg       <= tok_next;
        match_idx_reg <= match_idx_next;
        pick_idx_reg  <= pick_idx_next;
    end

    assign out_valid     = valid_reg;
    assign out_tok       = tok_reg;
    assign out_match_idx = match_idx_reg;
    assign out_pick_idx  = pick_idx_reg;

endmodule

[sv/peer_presence_table_top.sv]
// Peer presence table: SLOTS entries of 128-bit peer identifier plus last-seen tick.
//
// Input stream (s_axis): one beat per item. tuser carries the kind (register a
// heard peer, or query presence); tdata carries the identifier halves and the
// current tick. Output stream (m_axis): one result beat per input beat, in order.
// Configuration: cfg_we/cfg_index/cfg_data write alive_time (0) or appear_time (1);
// write only while the table is idle.
//
// Each item walks the row of cells, one cell per cycle; the last cell's token
// drives the write-back and the result. One item is in flight at a time, so a new
// beat is taken only once the previous result has reached the output register.
// A result stalled by m_axis_tready waits in the output register; a second one
// waits in a holding register, and the input stays closed until it moves out.
// Reset clears all identifiers (every slot empty), sets both times to 3000 and
// drops any item in flight.
module peer_presence_table_top #(
    parameter int SLOTS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // tdata: peer_id_high[63:0], peer_id_low[127:64], now[191:128]
    input  logic [ppt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: kind[0]
    input  logic                             s_axis_tuser,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: hit[0], slot[3:1], appeared[4], present[5], zero[7:6]
    output logic [ppt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppt_pkg::CFG_W-1:0]        cfg_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EXT_W = (IDX_W > ppt_pkg::SLOT_W) ? IDX_W : ppt_pkg::SLOT_W;

    // Cell row: stage 0 is the incoming beat, stage SLOTS the finished search
    logic              chain_valid [SLOTS+1];
    ppt_pkg::token_t   chain_tok   [SLOTS+1];
    logic [IDX_W-1:0]  chain_midx  [SLOTS+1];
    logic [IDX_W-1:0]  chain_pidx  [SLOTS+1];

    ppt_pkg::wb_t      wb;
    logic [IDX_W-1:0]  wb_idx;

    logic [ppt_pkg::CFG_W-1:0] alive_reg, alive_next;
    logic [ppt_pkg::CFG_W-1:0] appear_reg, appear_next;

    logic busy_reg, busy_next;
    logic out_valid_reg, out_valid_next;
    logic [ppt_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic hold_valid_reg, hold_valid_next;
    logic [ppt_pkg::OUT_DATA_W-1:0] hold_data_reg, hold_data_next;

    logic in_accept;
    logic out_free;
    logic busy_clear;

    ppt_pkg::token_t   fin_tok;
    logic [IDX_W-1:0]  fin_idx;
    logic [EXT_W-1:0]  fin_idx_ext;
    logic              res_hit;
    logic              res_appeared;
    logic              res_present;
    logic [ppt_pkg::OUT_DATA_W-1:0] res_data;

    assign s_axis_tready = !busy_reg;
    assign in_accept     = s_axis_tvalid && !busy_reg;

    // Seed the search token from the input beat
    always_comb
    begin
        chain_valid[0]          = in_accept;
        chain_tok[0].kind       = ppt_pkg::kind_t'(s_axis_tuser);
        chain_tok[0].id_high    = s_axis_tdata[ppt_pkg::ID_W-1:0];
        chain_tok[0].id_low     = s_axis_tdata[2*ppt_pkg::ID_W-1:ppt_pkg::ID_W];
        chain_tok[0].now        = s_axis_tdata[ppt_pkg::IN_DATA_W-1:2*ppt_pkg::ID_W];
        chain_tok[0].found      = 1'b0;
        chain_tok[0].have_empty = 1'b0;
        chain_tok[0].best_age   = '0;
        chain_tok[0].match_age  = '0;
        chain_midx[0]           = '0;
        chain_pidx[0]           = '0;
    end

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        ppt_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .in_valid      (chain_valid[g]),
            .in_tok        (chain_tok[g]),
            .in_match_idx  (chain_midx[g]),
            .in_pick_idx   (chain_pidx[g]),
            .out_valid     (chain_valid[g+1]),
            .out_tok       (chain_tok[g+1]),
            .out_match_idx (chain_midx[g+1]),
            .out_pick_idx  (chain_pidx[g+1]),
            .wb            (wb),
            .wb_idx        (wb_idx)
        );
    end

    // Resolve the finished search: result fields and write-back command
    assign fin_tok = chain_tok[SLOTS];

    always_comb
    begin
        res_hit      = 1'b0;
        res_appeared = 1'b0;
        res_present  = 1'b0;
        fin_idx      = '0;
        wb.en        = 1'b0;
        wb.set_id    = 1'b0;
        wb.id_high   = fin_tok.id_high;
        wb.id_low    = fin_tok.id_low;
        wb.now       = fin_tok.now;
        unique case (fin_tok.kind)
            ppt_pkg::KIND_REGISTER:
            begin
                wb.en = chain_valid[SLOTS];
                if (fin_tok.found)
                begin
                    res_hit      = 1'b1;
                    fin_idx      = chain_midx[SLOTS];
                    res_appeared = fin_tok.match_age > ppt_pkg::TIME_W'(appear_reg);
                end
                else
                begin
                    // claim last empty slot, else the oldest (slot 0 when none is older)
                    fin_idx      = chain_pidx[SLOTS];
                    res_appeared = 1'b1;
                    wb.set_id    = 1'b1;
                end
            end
            ppt_pkg::KIND_QUERY:
            begin
                if (fin_tok.found)
                begin
                    res_hit     = 1'b1;
                    fin_idx     = chain_midx[SLOTS];
                    res_present = fin_tok.match_age <= ppt_pkg::TIME_W'(alive_reg);
                end
            end
            default:
            begin
                res_hit = 1'b0;
            end
        endcase
    end

    assign wb_idx      = fin_idx;
    assign fin_idx_ext = EXT_W'(fin_idx);
    assign res_data    = {2'b00, res_present, res_appeared,
                          fin_idx_ext[ppt_pkg::SLOT_W-1:0], res_hit};

    // Output register plus one holding slot for a result that meets a stall
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        hold_valid_next = hold_valid_reg;
        hold_data_next  = hold_data_reg;
        busy_clear      = 1'b0;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (hold_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = hold_data_reg;
                hold_valid_next = 1'b0;
                busy_clear      = 1'b1;
            end
        end
        else if (chain_valid[SLOTS])
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res_data;
                busy_clear     = 1'b1;
            end
            else
            begin
                hold_valid_next = 1'b1;
                hold_data_next  = res_data;
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (in_accept)
        begin
            busy_next = 1'b1;
        end
        else if (busy_clear)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        alive_next  = alive_reg;
        appear_next = appear_reg;
        if (cfg_we)
        begin
            unique case (ppt_pkg::cfg_reg_t'(cfg_index))
                ppt_pkg::REG_ALIVE_TIME:  alive_next  = cfg_data;
                ppt_pkg::REG_APPEAR_TIME: appear_next = cfg_data;
                default:                  alive_next  = alive_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            alive_reg      <= ppt_pkg::CFG_W'(3000);
            appear_reg     <= ppt_pkg::CFG_W'(3000);
        end
        else
        begin
            busy_reg       <= busy_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
            alive_reg      <= alive_next;
            appear_reg     <= appear_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        hold_data_reg <= hold_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
